// ===== rtl/uedp_pkg.sv =====
// Shared types and constants for the USB endpoint descriptor parser.
`timescale 1ns / 1ps

package uedp_pkg;

	// Number of endpoint records kept per interface setting.
	localparam int MaxEndpoints = 32;
	localparam int SlotW = $clog2(MaxEndpoints + 1);

	// Descriptor type codes.
	localparam logic [7:0] TYPE_INTERFACE = 8'h04;
	localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
	localparam logic [7:0] TYPE_COMPANION = 8'h30;

	// Field masks.
	localparam logic [7:0]  DIR_IN_MASK  = 8'h80;
	localparam logic [15:0] MPS_MASK     = 16'h07FF;
	localparam logic [7:0]  XFER_MASK    = 8'h03;
	localparam logic [7:0]  STREAMS_MASK = 8'h1F;

	// Number of captured body bytes (offsets 2 to 6 of a descriptor).
	localparam int StageDepth = 5;

	// One accepted input word.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} byte_item_t;

	// Endpoint record under construction.
	typedef struct packed {
		logic [4:0]  ctx;
		logic [2:0]  kind;
		logic [10:0] mps;
		logic [1:0]  mult;
		logic [7:0]  interval;
		logic [7:0]  burst;
		logic [4:0]  streams;
		logic [15:0] bpi;
		logic        has_extra;
		logic [15:0] extra_off;
	} ep_record_t;

	// One result word.
	typedef struct packed {
		logic [4:0]  ep_slot;
		logic [4:0]  context_index;
		logic [2:0]  ep_kind;
		logic [10:0] packet_size;
		logic [1:0]  mult_count;
		logic [7:0]  poll_interval;
		logic [7:0]  burst_size;
		logic [4:0]  stream_exponent;
		logic [15:0] bytes_interval;
		logic        has_extra;
		logic [15:0] extra_offset;
		logic        finished;
	} ep_result_t;

endpackage

// ===== rtl/uedp_byte_if.sv =====
// Valid/ready channel carrying descriptor stream bytes.
`timescale 1ns / 1ps

interface uedp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

// ===== rtl/uedp_result_if.sv =====
// Valid/ready channel carrying endpoint records.
`timescale 1ns / 1ps

interface uedp_result_if;
	logic        valid;
	logic        ready;
	logic [4:0]  ep_slot;
	logic [4:0]  context_index;
	logic [2:0]  ep_kind;
	logic [10:0] packet_size;
	logic [1:0]  mult_count;
	logic [7:0]  poll_interval;
	logic [7:0]  burst_size;
	logic [4:0]  stream_exponent;
	logic [15:0] bytes_interval;
	logic        has_extra;
	logic [15:0] extra_offset;
	logic        finished;

	modport source (output valid, output ep_slot, output context_index, output ep_kind,
		output packet_size, output mult_count, output poll_interval, output burst_size,
		output stream_exponent, output bytes_interval, output has_extra,
		output extra_offset, output finished, input ready);
	modport sink (input valid, input ep_slot, input context_index, input ep_kind,
		input packet_size, input mult_count, input poll_interval, input burst_size,
		input stream_exponent, input bytes_interval, input has_extra,
		input extra_offset, input finished, output ready);
endinterface

// ===== rtl/uedp_in_stage.sv =====
// Input register stage holding one accepted stream byte.
`timescale 1ns / 1ps

module uedp_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  uedp_pkg::byte_item_t item,
	input  logic                fire,
	output logic                item_valid_s1,
	output uedp_pkg::byte_item_t item_s1
);
	import uedp_pkg::*;

	// Valid flag: set by a new word, cleared when the word moves on unreplaced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (load) begin
			item_valid_s1 <= 1'b1;
		end else if (fire) begin
			item_valid_s1 <= 1'b0;
		end
	end

	// Payload capture.
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end
endmodule

// ===== rtl/uedp_parse.sv =====
// Descriptor walker: parser state and the result of the current byte.
`timescale 1ns / 1ps

module uedp_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  uedp_pkg::byte_item_t item,
	output logic                 res_valid,
	output uedp_pkg::ep_result_t res
);
	import uedp_pkg::*;

	logic             active_q;
	logic [7:0]       byte_pos_q;
	logic [7:0]       desc_len_q;
	logic [7:0]       desc_type_q;
	logic [15:0]      region_off_q;
	logic [15:0]      desc_start_q;
	logic             have_ep_q;
	logic [SlotW-1:0] slots_q;
	logic [7:0]       stage_q [StageDepth];
	ep_record_t       rec_q;

	logic             act;
	logic [7:0]       pos;
	logic [7:0]       len_n;
	logic [7:0]       type_n;
	logic [15:0]      region_cur;
	logic [15:0]      start_n;
	logic             have_ep_n;
	logic [SlotW-1:0] slots_n;
	logic [7:0]       stage_n [StageDepth];
	ep_record_t       rec_n;
	logic [7:0]       pos_n;
	logic             emit;
	logic             fin;
	logic             done_desc;
	logic [15:0]      wval;
	logic [7:0]       addr;

	// Next state and result for the byte in the input register.
	always_comb begin
		act        = active_q;
		pos        = byte_pos_q;
		len_n      = desc_len_q;
		type_n     = desc_type_q;
		region_cur = region_off_q;
		start_n    = desc_start_q;
		have_ep_n  = have_ep_q;
		slots_n    = slots_q;
		stage_n    = stage_q;
		rec_n      = rec_q;
		emit       = 1'b0;
		fin        = 1'b0;
		done_desc  = 1'b0;
		pos_n      = byte_pos_q;
		wval       = 16'd0;
		addr       = 8'd0;

		// A first word restarts the region from a clean state.
		if (item.first_byte) begin
			act        = 1'b1;
			pos        = 8'd0;
			len_n      = 8'd0;
			type_n     = 8'd0;
			region_cur = 16'd0;
			start_n    = 16'd0;
			have_ep_n  = 1'b0;
			slots_n    = '0;
			for (int i = 0; i < StageDepth; i++) begin
				stage_n[i] = 8'd0;
			end
			rec_n = '0;
		end
		pos_n = pos;

		if (act) begin
			if (pos == 8'd0) begin
				// Length byte opens a new descriptor.
				start_n = region_cur;
				len_n   = item.data_byte;
				type_n  = 8'd0;
				for (int i = 0; i < StageDepth; i++) begin
					stage_n[i] = 8'd0;
				end
				fin   = (item.data_byte < 8'd2);
				pos_n = 8'd1;
			end else begin
				if (pos == 8'd1) begin
					// Type byte: interface ends the region; a type other than endpoint or companion marks the extra.
					type_n = item.data_byte;
					if (item.data_byte == TYPE_INTERFACE) begin
						fin = 1'b1;
					end else if (item.data_byte != TYPE_ENDPOINT &&
						item.data_byte != TYPE_COMPANION && have_ep_n && !rec_n.has_extra) begin
						rec_n.has_extra = 1'b1;
						rec_n.extra_off = start_n;
						emit            = 1'b1;
					end
				end else begin
					for (int i = 0; i < StageDepth; i++) begin
						if (pos == 8'(i + 2)) begin
							stage_n[i] = item.data_byte;
						end
					end
				end
				pos_n     = pos + 8'd1;
				done_desc = !fin && ({1'b0, pos} + 9'd1 == {1'b0, len_n});
				wval      = {stage_n[3], stage_n[2]};
				addr      = stage_n[0];

				// Last byte of a descriptor applies endpoint or companion fields.
				if (done_desc) begin
					if (type_n == TYPE_ENDPOINT) begin
						if (slots_n < SlotW'(MaxEndpoints)) begin
							rec_n          = '0;
							rec_n.ctx      = {addr[3:0], addr[7]};
							rec_n.kind     = 3'((addr & DIR_IN_MASK) >> 5) +
								3'(stage_n[1] & XFER_MASK);
							rec_n.mps      = 11'(wval & MPS_MASK);
							rec_n.mult     = wval[12:11];
							rec_n.interval = stage_n[4];
							slots_n        = slots_n + SlotW'(1);
							have_ep_n      = 1'b1;
							emit           = 1'b1;
						end else begin
							have_ep_n = 1'b0;
						end
					end else if (type_n == TYPE_COMPANION && have_ep_n) begin
						rec_n.burst   = stage_n[0];
						rec_n.streams = 5'(stage_n[1] & STREAMS_MASK);
						rec_n.bpi     = wval;
						emit          = 1'b1;
					end
					pos_n = 8'd0;
				end
			end
			if (item.last_byte) begin
				fin = 1'b1;
			end
		end

		// Result word.
		res_valid = act && (emit || fin);
		res       = '0;
		if (emit) begin
			res.ep_slot         = 5'(slots_n - SlotW'(1));
			res.context_index   = rec_n.ctx;
			res.ep_kind         = rec_n.kind;
			res.packet_size     = rec_n.mps;
			res.mult_count      = rec_n.mult;
			res.poll_interval   = rec_n.interval;
			res.burst_size      = rec_n.burst;
			res.stream_exponent = rec_n.streams;
			res.bytes_interval  = rec_n.bpi;
			res.has_extra       = rec_n.has_extra;
			res.extra_offset    = rec_n.has_extra ? rec_n.extra_off : 16'd0;
		end
		res.finished = fin;
	end

	// Parser state registers, updated once per consumed word while parsing is active.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			byte_pos_q   <= 8'd0;
			desc_len_q   <= 8'd0;
			desc_type_q  <= 8'd0;
			region_off_q <= 16'd0;
			desc_start_q <= 16'd0;
			have_ep_q    <= 1'b0;
			slots_q      <= '0;
			for (int i = 0; i < StageDepth; i++) begin
				stage_q[i] <= 8'd0;
			end
			rec_q <= '0;
		end else if (fire && act) begin
			active_q     <= !fin;
			byte_pos_q   <= pos_n;
			desc_len_q   <= len_n;
			desc_type_q  <= type_n;
			region_off_q <= region_cur + 16'd1;
			desc_start_q <= start_n;
			have_ep_q    <= have_ep_n;
			slots_q      <= slots_n;
			stage_q      <= stage_n;
			rec_q        <= rec_n;
		end
	end
endmodule

// ===== rtl/uedp_out_stage.sv =====
// Result register with valid flag in front of the output channel.
`timescale 1ns / 1ps

module uedp_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  uedp_pkg::ep_result_t res,
	input  logic                 take,
	output logic                 can_advance,
	output logic                 res_valid_q,
	output uedp_pkg::ep_result_t res_q
);
	import uedp_pkg::*;

	// The stage can move when the register is empty or being emptied.
	assign can_advance = !res_valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (take) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end
endmodule

// ===== rtl/usb_endpoint_descriptor_parser.sv =====
// Top level of the USB endpoint descriptor parser.
//
// Usage: desc_bytes carries the configuration descriptor one byte per word,
// starting with first_byte on the byte after an interface descriptor and
// marking the final byte with last_byte. ep_records carries one word for each
// endpoint, companion or first extra descriptor that updates the current
// endpoint record, and one with finished set when parsing of the region ends.
// Bytes arriving while parsing is not active and without first_byte are
// consumed silently.
// A result word passes through the input register, then the result register,
// before it is presented. Throughput: one byte per cycle while the result
// register is empty or being taken; the parser state is updated
// combinationally between the two registers.
// Reset clears all parser state and both valid flags; the block is idle until
// a word with first_byte arrives. When the receiver stalls, the result
// register holds its word, the input register fills, and desc_bytes.ready
// drops; a held byte waits even when it gives no result, and moves on as soon
// as the result register is empty or being taken, so no word is ever lost.
`timescale 1ns / 1ps

module usb_endpoint_descriptor_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	uedp_byte_if.sink             desc_bytes,
	uedp_result_if.source         ep_records
);
	import uedp_pkg::*;

	byte_item_t in_item;
	byte_item_t item_s1;
	logic       item_valid_s1;
	logic       can_advance;
	logic       fire;
	logic       accept;
	logic       res_valid;
	ep_result_t res;
	logic       out_valid_q;
	ep_result_t out_q;

	// Input handshake and advance of the held byte into the parser.
	assign fire              = item_valid_s1 && can_advance;
	assign desc_bytes.ready  = !item_valid_s1 || fire;
	assign accept            = desc_bytes.valid && desc_bytes.ready;
	assign in_item.data_byte  = desc_bytes.data_byte;
	assign in_item.first_byte = desc_bytes.first_byte;
	assign in_item.last_byte  = desc_bytes.last_byte;

	uedp_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.item         (in_item),
		.fire         (fire),
		.item_valid_s1(item_valid_s1),
		.item_s1      (item_s1)
	);

	uedp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	uedp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire && res_valid),
		.res        (res),
		.take       (ep_records.ready),
		.can_advance(can_advance),
		.res_valid_q(out_valid_q),
		.res_q      (out_q)
	);

	// Output channel drive.
	assign ep_records.valid           = out_valid_q;
	assign ep_records.ep_slot         = out_q.ep_slot;
	assign ep_records.context_index   = out_q.context_index;
	assign ep_records.ep_kind         = out_q.ep_kind;
	assign ep_records.packet_size     = out_q.packet_size;
	assign ep_records.mult_count      = out_q.mult_count;
	assign ep_records.poll_interval   = out_q.poll_interval;
	assign ep_records.burst_size      = out_q.burst_size;
	assign ep_records.stream_exponent = out_q.stream_exponent;
	assign ep_records.bytes_interval  = out_q.bytes_interval;
	assign ep_records.has_extra       = out_q.has_extra;
	assign ep_records.extra_offset    = out_q.extra_offset;
	assign ep_records.finished        = out_q.finished;
endmodule
